// ===== sv/tbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// tbpe_pkg : shared types and constants of the tape block pulse encoder
// Register indexes, reset values, result step codes and the structs that
// pass configuration and one result word between modules.
// ----------------------------------------------------------------------------
package tbpe_pkg;

  localparam int unsigned BIT_LEN_W   = 12;
  localparam int unsigned COUNT_W     = 14;
  localparam int unsigned GAP_W       = 22;
  localparam int unsigned LEVEL_W     = 2;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 22;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PILOT_PULSE_LEN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST_LEN     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND_LEN    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_BIT_LEN       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_BIT_LEN        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_PILOT_COUNT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_PILOT_COUNT   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP_LEN            = 3'd7;

  // Reset values
  localparam logic [BIT_LEN_W-1:0] RST_PILOT_PULSE_LEN    = 12'd2168;
  localparam logic [BIT_LEN_W-1:0] RST_SYNC_FIRST_LEN     = 12'd667;
  localparam logic [BIT_LEN_W-1:0] RST_SYNC_SECOND_LEN    = 12'd735;
  localparam logic [BIT_LEN_W-1:0] RST_ZERO_BIT_LEN       = 12'd855;
  localparam logic [BIT_LEN_W-1:0] RST_ONE_BIT_LEN        = 12'd1710;
  localparam logic [COUNT_W-1:0]   RST_HEADER_PILOT_COUNT = 14'd8063;
  localparam logic [COUNT_W-1:0]   RST_DATA_PILOT_COUNT   = 14'd3223;
  localparam logic [GAP_W-1:0]     RST_GAP_LEN            = 22'd3500000;

  // Output level codes
  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_GAP  = 2'd2;

  // Result steps of one input word, in emission order
  typedef logic [3:0] step_t;
  localparam step_t STEP_PILOT     = 4'd0;
  localparam step_t STEP_SYNC1     = 4'd1;
  localparam step_t STEP_SYNC2     = 4'd2;
  localparam step_t STEP_BIT_FIRST = 4'd3;
  localparam step_t STEP_BIT_LAST  = 4'd10;
  localparam step_t STEP_GAP       = 4'd11;

  typedef struct packed {
    logic [BIT_LEN_W-1:0] pilot_pulse_len;
    logic [BIT_LEN_W-1:0] sync_first_len;
    logic [BIT_LEN_W-1:0] sync_second_len;
    logic [BIT_LEN_W-1:0] zero_bit_len;
    logic [BIT_LEN_W-1:0] one_bit_len;
    logic [COUNT_W-1:0]   header_pilot_count;
    logic [COUNT_W-1:0]   data_pilot_count;
    logic [GAP_W-1:0]     gap_len;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [GAP_W-1:0]   pulse_len;
    logic [COUNT_W-1:0] repeat_res;
  } result_t;

endpackage

// ===== sv/tbpe_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tbpe_cfg_regs : configuration register file
// Eight write-only timing registers, each masked to its own width.
// ----------------------------------------------------------------------------
module tbpe_cfg_regs
  import tbpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pilot_pulse_len    <= RST_PILOT_PULSE_LEN;
      cfg.sync_first_len     <= RST_SYNC_FIRST_LEN;
      cfg.sync_second_len    <= RST_SYNC_SECOND_LEN;
      cfg.zero_bit_len       <= RST_ZERO_BIT_LEN;
      cfg.one_bit_len        <= RST_ONE_BIT_LEN;
      cfg.header_pilot_count <= RST_HEADER_PILOT_COUNT;
      cfg.data_pilot_count   <= RST_DATA_PILOT_COUNT;
      cfg.gap_len            <= RST_GAP_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PILOT_PULSE_LEN:    cfg.pilot_pulse_len    <= cfg_data[BIT_LEN_W-1:0];
        REG_SYNC_FIRST_LEN:     cfg.sync_first_len     <= cfg_data[BIT_LEN_W-1:0];
        REG_SYNC_SECOND_LEN:    cfg.sync_second_len    <= cfg_data[BIT_LEN_W-1:0];
        REG_ZERO_BIT_LEN:       cfg.zero_bit_len       <= cfg_data[BIT_LEN_W-1:0];
        REG_ONE_BIT_LEN:        cfg.one_bit_len        <= cfg_data[BIT_LEN_W-1:0];
        REG_HEADER_PILOT_COUNT: cfg.header_pilot_count <= cfg_data[COUNT_W-1:0];
        REG_DATA_PILOT_COUNT:   cfg.data_pilot_count   <= cfg_data[COUNT_W-1:0];
        REG_GAP_LEN:            cfg.gap_len            <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/tbpe_result_form.sv =====
// ----------------------------------------------------------------------------
// tbpe_result_form : forms one result word from the current step
// Pilot, sync, bit and gap results; zero lengths read as one.
// ----------------------------------------------------------------------------
module tbpe_result_form
  import tbpe_pkg::*;
(
  input  step_t   step,
  input  cfg_t    cfg,
  input  logic    flag_nz,
  input  logic    bit_val,
  output result_t res
);

  logic [COUNT_W-1:0]   limit_raw;
  logic [COUNT_W-1:0]   limit;
  logic [BIT_LEN_W-1:0] sel_len;

  function automatic logic [BIT_LEN_W-1:0] min_one(input logic [BIT_LEN_W-1:0] v);
    return (v == '0) ? BIT_LEN_W'(1) : v;
  endfunction

  always_comb begin
    limit_raw = flag_nz ? cfg.data_pilot_count : cfg.header_pilot_count;
    limit     = (limit_raw < COUNT_W'(2)) ? COUNT_W'(2) : limit_raw;
    sel_len   = bit_val ? cfg.one_bit_len : cfg.zero_bit_len;

    res.level      = LEVEL_LOW;
    res.pulse_len  = GAP_W'(min_one(sel_len));
    res.repeat_res = COUNT_W'(2);
    unique case (step) inside
      STEP_PILOT: begin
        res.pulse_len  = GAP_W'(min_one(cfg.pilot_pulse_len));
        res.repeat_res = limit - COUNT_W'(1);
      end
      STEP_SYNC1: begin
        res.level      = {1'b0, ~limit[0]};
        res.pulse_len  = GAP_W'(min_one(cfg.sync_first_len));
        res.repeat_res = COUNT_W'(1);
      end
      STEP_SYNC2: begin
        res.level      = {1'b0, limit[0]};
        res.pulse_len  = GAP_W'(min_one(cfg.sync_second_len));
        res.repeat_res = COUNT_W'(1);
      end
      [STEP_BIT_FIRST:STEP_BIT_LAST]: ;
      STEP_GAP: begin
        res.level      = LEVEL_GAP;
        res.pulse_len  = (cfg.gap_len == '0) ? GAP_W'(1) : cfg.gap_len;
        res.repeat_res = COUNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/tape_block_pulse_encoder.sv =====
// ----------------------------------------------------------------------------
// tape_block_pulse_encoder : tape image bytes to run-length pulse words
// Parses block length, flag and data bytes and emits pilot, sync, bit and
// gap pulse descriptions, one result word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Each accepted input word is decoded at once: the block parser state moves
// on in the accept cycle and a job register takes the list of results that
// word causes. The job then walks its steps, one result word a cycle while
// the output is not stalled, into the output register. Length bytes cause no
// result. A data byte gives 8 results (9 with the closing gap), a flag byte
// 11 or 12 (pilot, two syncs, 8 bits, maybe a gap), end of tape gives one
// gap. The input accepts a new word in the same cycle as the last result of
// the previous word enters the output register; the single job register
// holds the results of one word at a time. Configuration is read live
// while a job runs, so write it only while the block is idle.
// ----------------------------------------------------------------------------
module tape_block_pulse_encoder
  import tbpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input words
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   action,
  input  logic [7:0]             tape_byte,
  // result words
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LEVEL_W-1:0]     level,
  output logic [GAP_W-1:0]       pulse_len,
  output logic [COUNT_W-1:0]     repeat_res,
  output logic                   last
);

  typedef enum logic [1:0] {
    PH_LEN_LO,
    PH_LEN_HI,
    PH_FLAG,
    PH_DATA
  } phase_t;

  cfg_t    cfg;
  result_t res;

  // block parser state
  phase_t      byte_phase, byte_phase_next;
  logic [7:0]  length_low, length_low_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic        flag_nonzero, flag_nonzero_next;

  // job register: the results still owed for the current word
  logic        job_valid;
  step_t       job_step;
  logic        job_has_gap;
  logic        job_flag_nz;
  logic [7:0]  job_byte;

  // job load values from the decoder
  logic        load_job;
  step_t       ld_step;
  logic        ld_gap;
  logic        ld_flag;
  logic        flag_eff;
  logic [15:0] left_dec;

  logic        in_accept;
  logic        emit;
  logic        job_final;

  tbpe_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tbpe_result_form u_result_form (
    .step    (job_step),
    .cfg     (cfg),
    .flag_nz (job_flag_nz),
    .bit_val (job_byte[7]),
    .res     (res)
  );

  // Emit when a job is pending and the output register is free or draining.
  assign emit      = job_valid && (!out_valid || !out_stall);
  assign job_final = (job_step == STEP_GAP) || ((job_step == STEP_BIT_LAST) && !job_has_gap);
  // Hold input until the current job hands over its last result.
  assign in_stall  = job_valid && !(emit && job_final);
  assign in_accept = in_valid && !in_stall;

  // Decode the incoming word against the block parser state.
  always_comb begin
    byte_phase_next   = byte_phase;
    length_low_next   = length_low;
    bytes_left_next   = bytes_left;
    flag_nonzero_next = flag_nonzero;
    load_job          = 1'b0;
    ld_step           = STEP_GAP;
    ld_gap            = 1'b0;
    ld_flag           = flag_nonzero;
    flag_eff          = flag_nonzero;
    left_dec          = bytes_left - {15'd0, (bytes_left != 16'd0)};
    if (action) begin
      // end of tape: one gap, drop any partial block
      load_job          = 1'b1;
      ld_gap            = 1'b1;
      byte_phase_next   = PH_LEN_LO;
      bytes_left_next   = 16'd0;
      flag_nonzero_next = 1'b0;
    end else begin
      unique case (byte_phase) inside
        PH_LEN_LO: begin
          length_low_next = tape_byte;
          byte_phase_next = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          bytes_left_next = {tape_byte, length_low};
          // an empty block still carries its flag byte
          if ({tape_byte, length_low} == 16'd0) begin
            bytes_left_next = 16'd1;
          end
          byte_phase_next = PH_FLAG;
        end
        PH_FLAG, PH_DATA: begin
          if (byte_phase == PH_FLAG) begin
            flag_eff = (tape_byte != 8'd0);
          end
          flag_nonzero_next = flag_eff;
          bytes_left_next   = left_dec;
          load_job          = 1'b1;
          ld_flag           = flag_eff;
          ld_step           = (byte_phase == PH_FLAG) ? STEP_PILOT : STEP_BIT_FIRST;
          if (left_dec == 16'd0) begin
            // block done: gap only after a data block
            ld_gap          = flag_eff;
            byte_phase_next = PH_LEN_LO;
          end else begin
            byte_phase_next = PH_DATA;
          end
        end
        default: ;
      endcase
    end
  end

  // Parser state advances only on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= PH_LEN_LO;
      length_low   <= 8'd0;
      bytes_left   <= 16'd0;
      flag_nonzero <= 1'b0;
    end else if (in_accept) begin
      byte_phase   <= byte_phase_next;
      length_low   <= length_low_next;
      bytes_left   <= bytes_left_next;
      flag_nonzero <= flag_nonzero_next;
    end
  end

  // Job register: load on accept, advance one step per emitted result.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_step  <= STEP_GAP;
    end else begin
      if (emit) begin
        if (job_final) begin
          job_valid <= 1'b0;
        end else begin
          job_step <= job_step + step_t'(1);
        end
      end
      if (in_accept && load_job) begin
        job_valid <= 1'b1;
        job_step  <= ld_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && load_job) begin
      job_has_gap <= ld_gap;
      job_flag_nz <= ld_flag;
      job_byte    <= tape_byte;
    end else if (emit && (job_step >= STEP_BIT_FIRST) && (job_step <= STEP_BIT_LAST)) begin
      // shift the next bit, MSB first, into place
      job_byte <= {job_byte[6:0], 1'b0};
    end
  end

  // Output register: hold under stall, load on emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      level      <= res.level;
      pulse_len  <= res.pulse_len;
      repeat_res <= res.repeat_res;
      last       <= job_final;
    end
  end

endmodule

// ===== sv/tbpe_checker.sv =====
// ----------------------------------------------------------------------------
// tbpe_checker : port-level checks for the tape block pulse encoder
// Watches the result channel for handshake and value consistency.
// ----------------------------------------------------------------------------
module tbpe_checker
  import tbpe_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [LEVEL_W-1:0] level,
  input logic [GAP_W-1:0]   pulse_len,
  input logic [COUNT_W-1:0] repeat_res
);

  // a stalled result word stays offered
  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // no unused level code
  a_level_code : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level == LEVEL_LOW) || (level == LEVEL_HIGH) || (level == LEVEL_GAP))
    else $error("bad level code");

  // lengths and counts never zero
  a_nonzero : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pulse_len != '0) && (repeat_res != '0))
    else $error("zero pulse length or repeat");

  // a gap is a single pulse
  a_gap_single : assert property (@(posedge clk) disable iff (rst)
    out_valid && (level == LEVEL_GAP) |-> repeat_res == COUNT_W'(1))
    else $error("gap with repeat other than one");

endmodule

bind tape_block_pulse_encoder tbpe_checker u_tbpe_checker (.*);
